// File: design/crc8af_pkg.sv
package crc8af_pkg;

  // Frame geometry.
  localparam int FRAME_LENGTH_DEFAULT = 13;
  localparam int POS_W = 5;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Field widths.
  localparam int BYTE_W = 8;
  localparam int STATUS_W = 3;
  localparam int CRC_W = 8;

  // CRC-8, polynomial 0xD5, MSB first.
  localparam logic [CRC_W-1:0] CRC_POLY = 8'hD5;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ADDRESS_FIRST  = 2'd0,
    REG_ADDRESS_SECOND = 2'd1,
    REG_END_CHAR       = 2'd2
  } cfg_reg_t;

  localparam logic [BYTE_W-1:0] ADDRESS_FIRST_RESET  = 8'h43;
  localparam logic [BYTE_W-1:0] ADDRESS_SECOND_RESET = 8'h43;
  localparam logic [BYTE_W-1:0] END_CHAR_RESET       = 8'h0D;

  typedef enum logic [STATUS_W-1:0] {
    ST_VALID        = 3'd0,
    ST_BAD_ADDRESS  = 3'd1,
    ST_BAD_LENGTH   = 3'd2,
    ST_CRC_MISMATCH = 3'd3,
    ST_NO_END       = 3'd4
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic              frame_end;
  } byte_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] address_first;
    logic [BYTE_W-1:0] address_second;
    logic [BYTE_W-1:0] end_char;
  } cfg_t;

  // One byte through the CRC, eight shift steps.
  function automatic logic [CRC_W-1:0] crc8_update(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Lowercase ASCII hex digit of a nibble.
  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nibble);
    logic [BYTE_W-1:0] d;
    if (nibble < 4'd10) begin
      d = 8'h30 + {4'b0000, nibble};
    end else begin
      d = 8'h57 + {4'b0000, nibble};
    end
    return d;
  endfunction

endpackage

// File: design/crc8af_if.sv
interface crc8af_byte_if;
  logic                              valid;
  logic                              ready;
  logic [crc8af_pkg::BYTE_W-1:0]     frame_byte;
  logic                              frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface crc8af_result_if;
  logic                              valid;
  logic                              ready;
  logic [crc8af_pkg::STATUS_W-1:0]   status;
  logic [crc8af_pkg::CRC_W-1:0]      computed_crc;

  modport source (output valid, output status, output computed_crc, input ready);
  modport sink (input valid, input status, input computed_crc, output ready);
endinterface

// File: design/crc8af_front.sv
module crc8af_front (
  input  logic                   clk,
  input  logic                   rst,
  crc8af_byte_if.sink            frame,
  output logic                   stage_valid,
  output crc8af_pkg::byte_item_t stage_item,
  input  logic                   stage_take
);

  // The register frees up in the same cycle as the check stage takes its item.
  assign frame.ready = !stage_valid || stage_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (frame.ready) begin
      stage_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      stage_item.frame_byte <= frame.frame_byte;
      stage_item.frame_end  <= frame.frame_end;
    end
  end

endmodule

// File: design/crc8af_check.sv
module crc8af_check #(
  parameter int FRAME_LENGTH = crc8af_pkg::FRAME_LENGTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   stage_valid,
  input  crc8af_pkg::byte_item_t stage_item,
  input  crc8af_pkg::cfg_t       cfg,
  output logic                   stage_take,
  crc8af_result_if.source        result
);

  localparam int POS_W = crc8af_pkg::POS_W;
  localparam logic [POS_W-1:0] SPAN     = POS_W'(FRAME_LENGTH - 3);
  localparam logic [POS_W-1:0] SPAN_LO  = POS_W'(FRAME_LENGTH - 2);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LENGTH - 1);

  logic [POS_W-1:0]                byte_position;
  logic [crc8af_pkg::CRC_W-1:0]    running_crc;
  logic                            address_bad;
  logic                            crc_bad;
  logic                            end_bad;

  logic [crc8af_pkg::CRC_W-1:0]    running_crc_next;
  logic                            address_bad_next;
  logic                            crc_bad_next;
  logic                            end_bad_next;
  logic                            length_ok;
  crc8af_pkg::status_t             status_next;
  logic [crc8af_pkg::BYTE_W-1:0]   b;
  logic [POS_W-1:0]                pos;

  assign stage_take = stage_valid && (!result.valid || result.ready);
  assign b   = stage_item.frame_byte;
  assign pos = byte_position;

  always_comb begin
    address_bad_next = address_bad
                       || (pos == '0 && b != cfg.address_first)
                       || (pos == POS_W'(1) && b != cfg.address_second);
    if (pos < SPAN) begin
      running_crc_next = crc8af_pkg::crc8_update(running_crc, b);
    end else begin
      running_crc_next = running_crc;
    end
    crc_bad_next = crc_bad
                   || (pos == SPAN && b != crc8af_pkg::hex_digit(running_crc[7:4]))
                   || (pos == SPAN_LO && b != crc8af_pkg::hex_digit(running_crc[3:0]));
    end_bad_next = end_bad || (pos == LAST_POS && b != cfg.end_char);
    length_ok    = (pos != crc8af_pkg::POS_MAX) && (pos == LAST_POS);
    if (address_bad_next) begin
      status_next = crc8af_pkg::ST_BAD_ADDRESS;
    end else if (!length_ok) begin
      status_next = crc8af_pkg::ST_BAD_LENGTH;
    end else if (crc_bad_next) begin
      status_next = crc8af_pkg::ST_CRC_MISMATCH;
    end else if (end_bad_next) begin
      status_next = crc8af_pkg::ST_NO_END;
    end else begin
      status_next = crc8af_pkg::ST_VALID;
    end
  end

  // Frame state: cleared after the last byte, otherwise carried on.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_crc   <= '0;
      address_bad   <= 1'b0;
      crc_bad       <= 1'b0;
      end_bad       <= 1'b0;
    end else if (stage_take) begin
      if (stage_item.frame_end) begin
        byte_position <= '0;
        running_crc   <= '0;
        address_bad   <= 1'b0;
        crc_bad       <= 1'b0;
        end_bad       <= 1'b0;
      end else begin
        if (byte_position != crc8af_pkg::POS_MAX) begin
          byte_position <= byte_position + POS_W'(1);
        end
        running_crc <= running_crc_next;
        address_bad <= address_bad_next;
        crc_bad     <= crc_bad_next;
        end_bad     <= end_bad_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (stage_take && stage_item.frame_end) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_take && stage_item.frame_end) begin
      result.status       <= status_next;
      result.computed_crc <= running_crc_next;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    stage_take && stage_item.frame_end |=> byte_position == '0 && running_crc == '0)
    else $error("frame state not cleared after last byte");

  a_crc_frozen: assert property (@(posedge clk) disable iff (rst)
    stage_take && !stage_item.frame_end && byte_position >= SPAN |=> $stable(running_crc))
    else $error("crc changed outside its span");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(stage_take && stage_item.frame_end))
    else $error("result appeared without a last byte");

  a_valid_clean: assert property (@(posedge clk) disable iff (rst)
    stage_take && stage_item.frame_end && status_next == crc8af_pkg::ST_VALID
    |-> !address_bad_next && !crc_bad_next && !end_bad_next && length_ok)
    else $error("valid status with a failed check");

endmodule

// File: design/crc8_ascii_frame_checker.sv
// A last byte goes from the input register to the check stage, which loads
// the result register. One byte per cycle while the result register is free
// or emptied; the input register takes one byte while a result waits.
// Reset (rst, synchronous, active high) clears the frame state and both valid
// flags, and loads the address and end-of-line registers with 'C', 'C' and CR.
module crc8_ascii_frame_checker #(
  parameter int FRAME_LENGTH = crc8af_pkg::FRAME_LENGTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [crc8af_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [crc8af_pkg::CFG_DATA_W-1:0]  cfg_data,
  crc8af_byte_if.sink                       frame,
  crc8af_result_if.source                   result
);

  // The configuration registers live here. The user must see that they are written only
  // while the checker is idle (the block does not enforce it), so the check stage may read them directly.
  crc8af_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.address_first  <= crc8af_pkg::ADDRESS_FIRST_RESET;
      cfg.address_second <= crc8af_pkg::ADDRESS_SECOND_RESET;
      cfg.end_char       <= crc8af_pkg::END_CHAR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        crc8af_pkg::REG_ADDRESS_FIRST:  cfg.address_first  <= cfg_data;
        crc8af_pkg::REG_ADDRESS_SECOND: cfg.address_second <= cfg_data;
        crc8af_pkg::REG_END_CHAR:       cfg.end_char       <= cfg_data;
        default: begin
          // An index beyond the register list writes nothing.
        end
      endcase
    end
  end

  // The input register holds one received item. It is handed on to the check
  // stage whenever the result register is free or being emptied in the same
  // cycle, so bytes flow without a bubble.
  logic                   stage_valid;
  crc8af_pkg::byte_item_t stage_item;
  logic                   stage_take;

  crc8af_front u_front (
    .clk         (clk),
    .rst         (rst),
    .frame       (frame),
    .stage_valid (stage_valid),
    .stage_item  (stage_item),
    .stage_take  (stage_take)
  );

  // The check stage carries the byte position, the running CRC and the three
  // error flags. Each byte ahead of the hex digits goes through one CRC step,
  // and every byte meets the address, hex and end-of-line compares. On the
  // last byte of a frame it loads the result register with the highest-priority
  // status and the CRC, then clears the frame state for the next frame.
  crc8af_check #(
    .FRAME_LENGTH (FRAME_LENGTH)
  ) u_check (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage_item  (stage_item),
    .cfg         (cfg),
    .stage_take  (stage_take),
    .result      (result)
  );

endmodule
